### hdl/bces_pkg.sv
package bces_pkg;

    typedef enum logic [2:0] {
        EV_PRESS       = 3'd0,
        EV_DOUBLE      = 3'd1,
        EV_RELEASE     = 3'd2,
        EV_KEY_PRESS   = 3'd3,
        EV_KEY_RELEASE = 3'd4,
        EV_BOOT        = 3'd5
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t    kind;
        logic [3:0]  index;
        logic        last;
    } event_t;

    typedef struct packed {
        logic   valid;
        event_t evt;
    } evt_push_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPIRE,
        ST_CTRL,
        ST_BOOT,
        ST_KEY_REL,
        ST_KEY_PRS,
        ST_FLUSH
    } scan_state_t;

    // configuration register indexes
    localparam logic CFG_WINDOW = 1'b0;
    localparam logic CFG_MASK   = 1'b1;

    localparam logic [15:0] WINDOW_RESET = 16'd300;

    localparam logic [1:0] CLICK_NONE   = 2'd0;
    localparam logic [1:0] CLICK_SINGLE = 2'd1;
    localparam logic [1:0] CLICK_DOUBLE = 2'd2;
    localparam logic [1:0] CLICK_MAX    = 2'd3;

    // controls 0, 2 and 4 held together
    localparam logic [7:0] BOOT_COMBO = 8'h15;

    localparam int EVQ_DEPTH = 4;
    localparam int EVQ_PTR_W = 2;

endpackage

### hdl/button_click_event_scanner_unit.sv
// Button click event scanner. Each accepted item is one poll of the control buttons
// and keys (active low) with a millisecond timestamp; it yields zero to twelve event
// items, in order: an expired click (single or double press), per-control presses and
// releases (controls enabled in the mask count clicks instead of reporting a press),
// a one-time boot request when controls 0, 2 and 4 are held, a release of the most
// recent key, and at most one new key press. The final event of a poll has last_event
// set; a poll with no events produces nothing. s_ready stays low from a poll's acceptance
// while the scan steps through the expiry check, each control, boot check, key release,
// key press and flush, so a new poll waits for the last. One control is handled per cycle
// except while waiting on a full four-entry event queue. Configuration writes take effect on
// the next edge and should be made only while no poll is in flight.
module button_click_event_scanner_unit
    import bces_pkg::*;
#(
    parameter int CONTROL_COUNT = 8,
    parameter int KEY_COUNT     = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    // poll input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_now_ms,
    input  logic [7:0]  s_control_levels,
    input  logic [15:0] s_key_levels,
    // event output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_kind,
    output logic [3:0]  m_event_index,
    output logic        m_last_event
);

    logic [15:0] window_reg;
    logic [7:0]  mask_reg;

    evt_push_t push;
    logic      q_full;
    logic      q_valid;
    event_t    q_evt;
    logic      pop;

    // configuration registers: window and click-count enable mask
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
            mask_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_WINDOW: window_reg <= cfg_wdata;
                CFG_MASK:   mask_reg   <= cfg_wdata[7:0];
                default:    mask_reg   <= mask_reg;
            endcase
        end
    end

    // front: accept a poll and step through the scan, producing events
    bces_scan #(
        .CONTROL_COUNT (CONTROL_COUNT),
        .KEY_COUNT     (KEY_COUNT)
    ) u_scan (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_now_ms         (s_now_ms),
        .s_control_levels (s_control_levels),
        .s_key_levels     (s_key_levels),
        .window           (window_reg),
        .enable_mask      (mask_reg),
        .push             (push),
        .q_full           (q_full)
    );

    // short queue so the scan keeps going while the output side stalls
    bces_evq u_evq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (q_full),
        .pop     (pop),
        .q_valid (q_valid),
        .q_evt   (q_evt)
    );

    // back: registered output stage driving the event channel
    bces_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_evt         (q_evt),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_event_index (m_event_index),
        .m_last_event  (m_last_event)
    );

endmodule

### hdl/bces_scan.sv
module bces_scan
    import bces_pkg::*;
#(
    parameter int CONTROL_COUNT = 8,
    parameter int KEY_COUNT     = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_now_ms,
    input  logic [7:0]  s_control_levels,
    input  logic [15:0] s_key_levels,
    input  logic [15:0] window,
    input  logic [7:0]  enable_mask,
    output evt_push_t   push,
    input  logic        q_full
);

    localparam int CI_W = $clog2(CONTROL_COUNT);
    localparam logic [CI_W-1:0] CI_LAST = CI_W'(CONTROL_COUNT - 1);
    localparam logic [15:0] KEY_MASK = 16'((17'(1) << KEY_COUNT) - 17'(1));

    scan_state_t state_reg, state_next;
    logic [CI_W-1:0] ci_reg, ci_next;
    logic [7:0]  cprev_reg, cprev_next;
    logic [15:0] kprev_reg, kprev_next;
    logic [31:0] start_reg, start_next;
    logic [1:0]  count_reg, count_next;
    logic [2:0]  rc_reg, rc_next;
    logic [3:0]  rk_reg, rk_next;
    logic        boot_reg, boot_next;
    logic        pend_valid_reg, pend_valid_next;
    event_t      pend_reg, pend_next;

    logic [31:0] now_reg;
    logic [7:0]  ctl_reg;
    logic [15:0] keys_reg;

    logic [31:0] elapsed;
    logic        evt_valid;
    ev_kind_t    evt_kind;
    logic [3:0]  evt_index;
    logic        flush;
    logic        need_push;
    logic        fire;

    logic [15:0] press_mask;
    logic        press_any;
    logic [3:0]  press_idx;
    logic [15:0] key_upd;
    logic        key_rel;

    assign s_ready = (state_reg == ST_IDLE);
    assign elapsed = now_reg - start_reg;

    // key scan: first new press, release of the recent key below it
    always_comb begin
        press_mask = kprev_reg & ~keys_reg & KEY_MASK;
        press_any  = |press_mask;
        press_idx  = '0;
        for (int j = 15; j >= 0; j--) begin
            if (press_mask[j]) begin
                press_idx = 4'(j);
            end
        end
        for (int j = 0; j < 16; j++) begin
            if (KEY_MASK[j] && (!press_any || 4'(j) < press_idx)) begin
                key_upd[j] = keys_reg[j];
            end else if (press_any && 4'(j) == press_idx) begin
                key_upd[j] = 1'b0;
            end else begin
                key_upd[j] = kprev_reg[j];
            end
        end
        key_rel = !kprev_reg[rk_reg] && keys_reg[rk_reg] && KEY_MASK[rk_reg]
                  && (!press_any || rk_reg < press_idx);
    end

    always_comb begin
        state_next = state_reg;
        ci_next    = ci_reg;
        cprev_next = cprev_reg;
        kprev_next = kprev_reg;
        start_next = start_reg;
        count_next = count_reg;
        rc_next    = rc_reg;
        rk_next    = rk_reg;
        boot_next  = boot_reg;
        evt_valid  = 1'b0;
        evt_kind   = EV_PRESS;
        evt_index  = '0;
        flush      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXPIRE;
                end
            end
            ST_EXPIRE: begin
                if (elapsed > {16'd0, window}) begin
                    if (count_reg >= CLICK_DOUBLE) begin
                        evt_valid = 1'b1;
                        evt_kind  = EV_DOUBLE;
                        evt_index = {1'b0, rc_reg};
                    end else if (count_reg == CLICK_SINGLE) begin
                        evt_valid = 1'b1;
                        evt_kind  = EV_PRESS;
                        evt_index = {1'b0, rc_reg};
                    end
                    count_next = CLICK_NONE;
                end
                ci_next    = '0;
                state_next = ST_CTRL;
            end
            ST_CTRL: begin
                if (cprev_reg[ci_reg] && !ctl_reg[ci_reg]) begin
                    if (enable_mask[ci_reg]) begin
                        if (elapsed < {16'd0, window} && rc_reg == 3'(ci_reg)) begin
                            if (count_reg != CLICK_MAX) begin
                                count_next = count_reg + 2'd1;
                            end
                        end else begin
                            start_next = now_reg;
                            count_next = CLICK_SINGLE;
                        end
                    end else begin
                        evt_valid = 1'b1;
                        evt_kind  = EV_PRESS;
                        evt_index = 4'(ci_reg);
                    end
                    rc_next = 3'(ci_reg);
                end else if (!cprev_reg[ci_reg] && ctl_reg[ci_reg]) begin
                    evt_valid = 1'b1;
                    evt_kind  = EV_RELEASE;
                    evt_index = 4'(ci_reg);
                end
                cprev_next[ci_reg] = ctl_reg[ci_reg];
                if (ci_reg == CI_LAST) begin
                    state_next = ST_BOOT;
                end else begin
                    ci_next = ci_reg + 1'b1;
                end
            end
            ST_BOOT: begin
                if ((cprev_reg & BOOT_COMBO) == 8'd0 && !boot_reg) begin
                    boot_next = 1'b1;
                    evt_valid = 1'b1;
                    evt_kind  = EV_BOOT;
                    evt_index = '0;
                end
                state_next = ST_KEY_REL;
            end
            ST_KEY_REL: begin
                if (key_rel) begin
                    evt_valid = 1'b1;
                    evt_kind  = EV_KEY_RELEASE;
                    evt_index = rk_reg;
                end
                state_next = ST_KEY_PRS;
            end
            ST_KEY_PRS: begin
                if (press_any) begin
                    evt_valid = 1'b1;
                    evt_kind  = EV_KEY_PRESS;
                    evt_index = press_idx;
                    rk_next   = press_idx;
                end
                kprev_next = key_upd;
                state_next = ST_FLUSH;
            end
            ST_FLUSH: begin
                flush      = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // hold one event back so the final one of a poll can carry the last flag
    always_comb begin
        need_push       = (evt_valid || flush) && pend_valid_reg;
        fire            = !need_push || !q_full;
        push.valid      = need_push && fire;
        push.evt.kind   = pend_reg.kind;
        push.evt.index  = pend_reg.index;
        push.evt.last   = flush;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (evt_valid) begin
            pend_valid_next = 1'b1;
            pend_next.kind  = evt_kind;
            pend_next.index = evt_index;
            pend_next.last  = 1'b0;
        end else if (flush) begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ci_reg         <= '0;
            cprev_reg      <= '1;
            kprev_reg      <= '1;
            start_reg      <= '0;
            count_reg      <= CLICK_NONE;
            rc_reg         <= '0;
            rk_reg         <= '0;
            boot_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (fire) begin
            state_reg      <= state_next;
            ci_reg         <= ci_next;
            cprev_reg      <= cprev_next;
            kprev_reg      <= kprev_next;
            start_reg      <= start_next;
            count_reg      <= count_next;
            rc_reg         <= rc_next;
            rk_reg         <= rk_next;
            boot_reg       <= boot_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            pend_reg <= pend_next;
        end
        if (s_valid && s_ready) begin
            now_reg  <= s_now_ms;
            ctl_reg  <= s_control_levels;
            keys_reg <= s_key_levels;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> !q_full)
        else $error("scan pushed into a full queue");

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("pending event left behind at end of poll");

    a_flush_sets_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.valid && state_reg == ST_FLUSH) |-> push.evt.last)
        else $error("final event of poll missing last flag");

    a_accept_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == ST_EXPIRE)
        else $error("accepted poll did not start a scan");
`endif

endmodule

### hdl/bces_evq.sv
module bces_evq
    import bces_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  evt_push_t push,
    output logic      full,
    input  logic      pop,
    output logic      q_valid,
    output event_t    q_evt
);

    event_t mem [EVQ_DEPTH];
    logic [EVQ_PTR_W-1:0] wr_ptr_reg;
    logic [EVQ_PTR_W-1:0] rd_ptr_reg;
    logic [EVQ_PTR_W:0]   count_reg;
    logic                 do_pop;

    assign full    = (count_reg == (EVQ_PTR_W + 1)'(EVQ_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_evt   = mem[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem[wr_ptr_reg] <= push.evt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push.valid && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !push.valid) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hdl/bces_emit.sv
module bces_emit
    import bces_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  event_t     q_evt,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_event_kind,
    output logic [3:0] m_event_index,
    output logic       m_last_event
);

    logic   out_valid_reg;
    event_t out_evt_reg;

    // refill when empty or when the held item leaves this cycle
    assign pop           = q_valid && (!out_valid_reg || m_ready);
    assign m_valid       = out_valid_reg;
    assign m_event_kind  = out_evt_reg.kind;
    assign m_event_index = out_evt_reg.index;
    assign m_last_event  = out_evt_reg.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_evt_reg <= q_evt;
        end
    end

endmodule

### tb/tb_button_click_event_scanner_unit.sv
module tb_button_click_event_scanner_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bces_pkg::*;

    localparam int CTRL_TOTAL    = 8;
    localparam int KEY_TOTAL     = 16;
    // Slowest legal item: a long sender gap, the scan and twelve events that each wait
    // out a long sink stall; about 420 items plus the settle pauses make up the run,
    // so allow several times their total.
    localparam int LIMIT_CYCLES  = 1_500_000;
    // Give a poll with no events room to finish its scan.
    localparam int SETTLE_CYCLES = 40;

    logic        aclk             = 1'b0;
    logic        aresetn          = 1'b0;
    logic        cfg_wr_en        = 1'b0;
    logic        cfg_index        = CFG_WINDOW;
    logic [15:0] cfg_wdata        = 16'd0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [31:0] s_now_ms         = 32'd0;
    logic [7:0]  s_control_levels = 8'hFF;
    logic [15:0] s_key_levels     = 16'hFFFF;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [2:0]  m_event_kind;
    logic [3:0]  m_event_index;
    logic        m_last_event;

    // Scanner state as seen by the predictor.
    logic [15:0] window_ms;
    logic [7:0]  click_mask;
    logic [7:0]  seen_ctl;
    logic [15:0] seen_keys;
    logic [31:0] click_t0;
    logic [1:0]  click_cnt;
    logic [2:0]  last_ctl;
    logic [3:0]  last_key;
    logic        boot_seen;

    event_t      poll_events[$];      // events of the poll being predicted
    event_t      expected_events[$];  // events still owed by the block, oldest first

    // Last poll sent; the random sequences drift from it.
    logic [31:0] drv_time  = 32'd0;
    logic [7:0]  drv_ctl   = 8'hFF;
    logic [15:0] drv_keys  = 16'hFFFF;

    bit          idle_off    = 1'b0;
    int          sink_wait   = 0;
    int          fail_count  = 0;
    int          cycle_count = 0;

    button_click_event_scanner_unit #(
        .CONTROL_COUNT (CTRL_TOTAL),
        .KEY_COUNT     (KEY_TOTAL)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_now_ms         (s_now_ms),
        .s_control_levels (s_control_levels),
        .s_key_levels     (s_key_levels),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_kind     (m_event_kind),
        .m_event_index    (m_event_index),
        .m_last_event     (m_last_event)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Gap length: mostly a few cycles, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(99) < 85)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic void reset_model();
        window_ms  = WINDOW_RESET;
        click_mask = 8'h00;
        seen_ctl   = 8'hFF;
        seen_keys  = 16'hFFFF;
        click_t0   = 32'd0;
        click_cnt  = CLICK_NONE;
        last_ctl   = 3'd0;
        last_key   = 4'd0;
        boot_seen  = 1'b0;
    endfunction

    function automatic void note_event(input ev_kind_t kind, input logic [3:0] idx);
        event_t ev;
        ev.kind  = kind;
        ev.index = idx;
        ev.last  = 1'b0;
        poll_events.push_back(ev);
    endfunction

    // Work out the events that one poll causes and queue them as expected.
    function automatic void predict_poll_events(input logic [31:0] t, input logic [7:0] ctl,
                                                input logic [15:0] keys);
        logic [31:0] elapsed;
        logic        key_pressed;
        event_t      ev;
        int          i;
        poll_events.delete();

        // Flush a click whose window has run out.
        elapsed = t - click_t0;
        if (elapsed > {16'd0, window_ms}) begin
            if (click_cnt >= CLICK_DOUBLE)
                note_event(EV_DOUBLE, {1'b0, last_ctl});
            else if (click_cnt == CLICK_SINGLE)
                note_event(EV_PRESS, {1'b0, last_ctl});
            click_cnt = CLICK_NONE;
        end

        // Controls in order; the start time may move within the poll, so recompute.
        for (i = 0; i < CTRL_TOTAL; i++) begin
            if (seen_ctl[i] && !ctl[i]) begin
                if (click_mask[i]) begin
                    elapsed = t - click_t0;
                    if (elapsed < {16'd0, window_ms} && last_ctl == 3'(i)) begin
                        if (click_cnt != CLICK_MAX)
                            click_cnt = click_cnt + 2'd1;
                    end else begin
                        click_t0  = t;
                        click_cnt = CLICK_SINGLE;
                    end
                end else begin
                    note_event(EV_PRESS, 4'(i));
                end
                last_ctl = 3'(i);
            end else if (!seen_ctl[i] && ctl[i]) begin
                note_event(EV_RELEASE, 4'(i));
            end
            seen_ctl[i] = ctl[i];
        end

        // Boot combination, reported once per run.
        if ((seen_ctl & BOOT_COMBO) == 8'h00 && !boot_seen) begin
            boot_seen = 1'b1;
            note_event(EV_BOOT, 4'd0);
        end

        // Keys: releases of the recent key, stop at the first new press.
        key_pressed = 1'b0;
        for (i = 0; i < KEY_TOTAL && !key_pressed; i++) begin
            if (seen_keys[i] && !keys[i]) begin
                note_event(EV_KEY_PRESS, 4'(i));
                last_key     = 4'(i);
                seen_keys[i] = 1'b0;
                key_pressed  = 1'b1;
            end else begin
                if (!seen_keys[i] && keys[i] && last_key == 4'(i))
                    note_event(EV_KEY_RELEASE, 4'(i));
                seen_keys[i] = keys[i];
            end
        end

        // Flag the final event of the poll.
        if (poll_events.size() > 0) begin
            ev      = poll_events.pop_back();
            ev.last = 1'b1;
            poll_events.push_back(ev);
        end
        foreach (poll_events[j])
            expected_events.push_back(poll_events[j]);
    endfunction

    // Write one register; only called while the block is idle.
    task automatic write_reg(input logic idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_WINDOW)
            window_ms = value;
        else
            click_mask = value[7:0];
    endtask

    // Offer one poll item, sometimes after a random gap, and hold it until accepted.
    task automatic send_poll(input logic [31:0] t, input logic [7:0] ctl,
                             input logic [15:0] keys);
        int gap;
        gap = 0;
        if (!idle_off && $urandom_range(99) >= 55)
            gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_now_ms         <= t;
        s_control_levels <= ctl;
        s_key_levels     <= keys;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_poll_events(t, ctl, keys);
        drv_time = t;
        drv_ctl  = ctl;
        drv_keys = keys;
    endtask

    // Drop valid, let every owed event arrive, then give the scan time to go idle.
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Polls that drift from the last one: time advances a little, a few levels flip,
    // with one favored control so clicks pile up. noise_pct of them are fully random.
    task automatic random_polls(input int count, input int max_step, input int noise_pct);
        logic [31:0] t;
        logic [7:0]  ctl;
        logic [15:0] keys;
        int          n;
        int          fav;
        fav = $urandom_range(CTRL_TOTAL - 1);
        for (n = 0; n < count; n++) begin
            if ($urandom_range(99) < noise_pct) begin
                t    = $urandom;
                ctl  = 8'($urandom);
                keys = 16'($urandom);
            end else begin
                t    = drv_time + $urandom_range(max_step);
                ctl  = drv_ctl;
                keys = drv_keys;
                repeat ($urandom_range(2)) begin
                    if ($urandom_range(99) < 60)
                        ctl[fav] = ~ctl[fav];
                    else
                        ctl[$urandom_range(CTRL_TOTAL - 1)] ^= 1'b1;
                end
                repeat ($urandom_range(2))
                    keys[$urandom_range(KEY_TOTAL - 1)] ^= 1'b1;
                if ($urandom_range(99) < 10)
                    fav = $urandom_range(CTRL_TOTAL - 1);
            end
            send_poll(t, ctl, keys);
        end
    endtask

    // An expired single click, a release, seven presses, the boot request and a key
    // release followed by a key press: the fullest poll there is.
    task automatic test_max_burst();
        write_reg(CFG_MASK, 16'h0002);
        send_poll(32'd100, 8'hFD, 16'hFFFE);
        send_poll(32'd500, 8'h02, 16'hFFFD);
        settle();
        write_reg(CFG_MASK, 16'h0000);
    endtask

    // Immediate presses and releases, the boot combination held again, time extremes.
    task automatic test_plain_events();
        send_poll(32'd510, 8'hFF, 16'hFFFF);
        send_poll(32'd520, 8'h00, 16'hFFFF);
        send_poll(32'd540, 8'hEA, 16'hFFFF);
        send_poll(32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        send_poll(32'd0, 8'hFF, 16'hFFFF);
        settle();
    endtask

    // Only the first new key per poll; later keys show up next poll; only the
    // recent key reports a release.
    task automatic test_key_order();
        send_poll(32'd10, 8'hFF, 16'h7FFE);
        send_poll(32'd20, 8'hFF, 16'h7FFE);
        send_poll(32'd30, 8'hFF, 16'hFFFE);
        send_poll(32'd40, 8'hFF, 16'h0000);
        send_poll(32'd50, 8'hFF, 16'hFFFF);
        settle();
    endtask

    // Click counting up to the top count, expiry as a double press, timestamp wrap and a
    // zero window.
    task automatic test_click_counting();
        write_reg(CFG_MASK, 16'h00FF);
        write_reg(CFG_WINDOW, WINDOW_RESET);
        send_poll(32'd1000, 8'hFE, 16'hFFFF);
        send_poll(32'd1050, 8'hFF, 16'hFFFF);
        send_poll(32'd1100, 8'hFE, 16'hFFFF);
        send_poll(32'd1150, 8'hFF, 16'hFFFF);
        send_poll(32'd1200, 8'hFE, 16'hFFFF);
        send_poll(32'd1250, 8'hFF, 16'hFFFF);
        send_poll(32'd1300, 8'hFE, 16'hFFFF);
        send_poll(32'd1700, 8'hFF, 16'hFFFF);
        // Wrap: the window spans the rollover of the millisecond counter.
        send_poll(32'hFFFF_FFFF, 8'hFE, 16'hFFFF);
        send_poll(32'h0000_0010, 8'hFF, 16'hFFFF);
        send_poll(32'h0000_0020, 8'hFE, 16'hFFFF);
        settle();
        write_reg(CFG_WINDOW, 16'd0);
        send_poll(32'd3000, 8'hFF, 16'hFFFF);
        send_poll(32'd3000, 8'hFE, 16'hFFFF);
        send_poll(32'd3001, 8'hFF, 16'hFFFF);
        settle();
    endtask

    // Default window, mask off then random; the first stretch runs without gaps.
    task automatic test_random_mixed();
        write_reg(CFG_WINDOW, WINDOW_RESET);
        write_reg(CFG_MASK, 16'h0000);
        idle_off = 1'b1;
        random_polls(30, 200, 10);
        idle_off = 1'b0;
        random_polls(30, 200, 10);
        settle();
        write_reg(CFG_MASK, 16'($urandom_range(255)));
        random_polls(70, 200, 10);
        settle();
    endtask

    // Several random windows and masks with steps around the window size.
    task automatic test_random_click_windows();
        int p;
        for (p = 0; p < 4; p++) begin
            write_reg(CFG_WINDOW, 16'($urandom_range(500, 20)));
            write_reg(CFG_MASK, 16'($urandom_range(255)));
            random_polls(30, 150, 5);
            settle();
        end
    endtask

    // Zero and widest window with every control counting clicks.
    task automatic test_window_extremes();
        write_reg(CFG_MASK, 16'h00FF);
        write_reg(CFG_WINDOW, 16'd0);
        random_polls(40, 20, 10);
        settle();
        write_reg(CFG_WINDOW, 16'hFFFF);
        random_polls(40, 200, 20);
        settle();
    endtask

    // Fully random polls over random registers, half of them back to back.
    task automatic test_random_noise();
        write_reg(CFG_WINDOW, 16'($urandom));
        write_reg(CFG_MASK, 16'($urandom_range(255)));
        random_polls(30, 100, 100);
        idle_off = 1'b1;
        random_polls(30, 100, 100);
        idle_off = 1'b0;
        settle();
    endtask

    // Sink: accept most cycles, stall for random stretches.
    always @(posedge aclk) begin
        if (sink_wait > 0) begin
            sink_wait <= sink_wait - 1;
        end else if (idle_off || $urandom_range(99) < 70) begin
            m_ready <= 1'b1;
        end else begin
            m_ready   <= 1'b0;
            sink_wait <= idle_len() - 1;
        end
    end

    // Compare each accepted event with the oldest one owed.
    always @(posedge aclk) begin
        event_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_events.size() == 0) begin
                $error("unexpected event: kind %0d index %0d last %0d",
                       m_event_kind, m_event_index, m_last_event);
                fail_count++;
            end else begin
                want = expected_events.pop_front();
                if (m_event_kind !== want.kind) begin
                    $error("event_kind mismatch: expected %0d, actual %0d",
                           want.kind, m_event_kind);
                    fail_count++;
                end
                if (m_event_index !== want.index) begin
                    $error("event_index mismatch: expected %0d, actual %0d",
                           want.index, m_event_index);
                    fail_count++;
                end
                if (m_last_event !== want.last) begin
                    $error("last_event mismatch: expected %0d, actual %0d",
                           want.last, m_last_event);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        reset_model();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_max_burst();
        test_plain_events();
        test_key_order();
        test_click_counting();
        test_random_mixed();
        test_random_click_windows();
        test_window_extremes();
        test_random_noise();

        settle();
        if (fail_count == 0 && expected_events.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### button_click_event_scanner_unit.f
hdl/bces_pkg.sv
hdl/bces_scan.sv
hdl/bces_evq.sv
hdl/bces_emit.sv
hdl/button_click_event_scanner_unit.sv
tb/tb_button_click_event_scanner_unit.sv
